// ----- hdl/imm_pkg.sv -----
package imm_pkg;

	localparam int MAX_ROWS  = 16;
	localparam int MAX_INNER = 16;
	localparam int MAX_COLS  = 16;

	localparam int LEFT_DEPTH  = MAX_ROWS * MAX_INNER;
	localparam int RIGHT_DEPTH = MAX_INNER * MAX_COLS;
	localparam int LEFT_AW     = (LEFT_DEPTH > 1) ? $clog2(LEFT_DEPTH) : 1;
	localparam int RIGHT_AW    = (RIGHT_DEPTH > 1) ? $clog2(RIGHT_DEPTH) : 1;

	// Inner loop counter and the clamped size counts.
	localparam int INNER_IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
	localparam int ROW_CW   = $clog2(MAX_ROWS + 1);
	localparam int INNER_CW = $clog2(MAX_INNER + 1);
	localparam int COL_CW   = $clog2(MAX_COLS + 1);

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 5;
	localparam int CFG_IW  = 2;

	localparam logic [1:0] FUNC_WRITE_A = 2'd0;
	localparam logic [1:0] FUNC_WRITE_B = 2'd1;
	localparam logic [1:0] FUNC_COMPUTE = 2'd2;

	localparam logic [CFG_IW-1:0] CFG_ROW_COUNT   = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_INNER_COUNT = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_COL_COUNT   = 2'd2;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

	typedef enum logic [2:0] {
		STEP_IDLE,
		STEP_ISSUE,
		STEP_DRAIN1,
		STEP_DRAIN2,
		STEP_EMIT
	} step_t;

	typedef enum logic [1:0] {
		COND_ALWAYS,
		COND_DISPATCH,
		COND_LAST,
		COND_OUT_FREE
	} cond_t;

	typedef struct packed {
		logic  take_in;
		logic  issue;
		logic  emit;
		cond_t cond;
		step_t jmp;
		step_t alt;
	} ctrl_t;

	// Control store. A step whose condition fails stays where it is,
	// except the dispatch step, which branches to alt for a request that
	// needs no multiply-accumulate pass.
	function automatic ctrl_t ucode_rom(step_t step);
		ctrl_t w;
		unique case (step)
			STEP_IDLE:   w = '{1'b1, 1'b0, 1'b0, COND_DISPATCH, STEP_ISSUE, STEP_EMIT};
			STEP_ISSUE:  w = '{1'b0, 1'b1, 1'b0, COND_LAST, STEP_DRAIN1, STEP_ISSUE};
			STEP_DRAIN1: w = '{1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_DRAIN2, STEP_DRAIN2};
			STEP_DRAIN2: w = '{1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_EMIT, STEP_EMIT};
			STEP_EMIT:   w = '{1'b0, 1'b0, 1'b1, COND_OUT_FREE, STEP_IDLE, STEP_EMIT};
			default:     w = '{1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_IDLE, STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ----- hdl/imm_ram.sv -----
module imm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/integer_matrix_multiply.sv -----
// Writes of A or B elements are taken every cycle while no C request is in progress. A C
// request runs the multiply-accumulate loop, reading one A/B pair per cycle, then presents
// its result word; the next word can be taken as that word appears, and a stalled result
// adds its wait. Requests outside the sizes or with inner_count zero skip the loop.
// arst_n clears the sequencer, the pipeline flags and the output valid; size registers reset
// to 16. The element stores are not cleared and hold garbage until written.
module integer_matrix_multiply (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          func,
	input  logic [3:0]                          row_index,
	input  logic [3:0]                          col_index,
	input  logic signed [imm_pkg::DATA_W-1:0]   element_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [imm_pkg::DATA_W-1:0]   product_value,
	output logic                                status,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [imm_pkg::CFG_IW-1:0]          cfg_index,
	input  logic [imm_pkg::COUNT_W-1:0]         cfg_data
);

	imm_pkg::step_t step_q;
	imm_pkg::step_t step_next;
	imm_pkg::ctrl_t ctrl;

	logic [imm_pkg::COUNT_W-1:0]  row_count_q;
	logic [imm_pkg::COUNT_W-1:0]  inner_count_q;
	logic [imm_pkg::COUNT_W-1:0]  col_count_q;
	logic [imm_pkg::ROW_CW-1:0]   rows_eff;
	logic [imm_pkg::INNER_CW-1:0] inner_eff;
	logic [imm_pkg::COL_CW-1:0]   cols_eff;

	logic [imm_pkg::INNER_IW-1:0] l_q;
	logic [3:0]                   req_row_q;
	logic [3:0]                   req_col_q;
	logic                         err_q;
	logic [imm_pkg::DATA_W-1:0]   acc_q;
	logic                         rd_vld_s1;
	logic [imm_pkg::DATA_W-1:0]   prod_s2;
	logic                         prod_vld_s2;
	logic                         out_valid_q;
	logic [imm_pkg::DATA_W-1:0]   product_value_q;
	logic                         status_q;

	logic                         in_take;
	logic                         is_compute;
	logic                         pos_ok;
	logic                         go_mac;
	logic                         go_emit;
	logic                         last;
	logic                         out_free;

	logic                         a_we;
	logic                         b_we;
	logic [imm_pkg::LEFT_AW-1:0]  a_waddr;
	logic [imm_pkg::RIGHT_AW-1:0] b_waddr;
	logic [imm_pkg::LEFT_AW-1:0]  a_raddr;
	logic [imm_pkg::RIGHT_AW-1:0] b_raddr;
	logic [imm_pkg::DATA_W-1:0]   a_rdata;
	logic [imm_pkg::DATA_W-1:0]   b_rdata;

	// Counts above the store dimensions behave as the dimension itself.
	assign rows_eff = (32'(row_count_q) > imm_pkg::MAX_ROWS) ?
		imm_pkg::ROW_CW'(imm_pkg::MAX_ROWS) : imm_pkg::ROW_CW'(row_count_q);
	assign inner_eff = (32'(inner_count_q) > imm_pkg::MAX_INNER) ?
		imm_pkg::INNER_CW'(imm_pkg::MAX_INNER) : imm_pkg::INNER_CW'(inner_count_q);
	assign cols_eff = (32'(col_count_q) > imm_pkg::MAX_COLS) ?
		imm_pkg::COL_CW'(imm_pkg::MAX_COLS) : imm_pkg::COL_CW'(col_count_q);

	assign ctrl     = imm_pkg::ucode_rom(step_q);
	assign in_stall = !ctrl.take_in;
	assign in_take  = in_valid && ctrl.take_in;

	assign is_compute = (func == imm_pkg::FUNC_COMPUTE);
	assign pos_ok = (32'(row_index) < 32'(rows_eff)) && (32'(col_index) < 32'(cols_eff));
	// A request with an empty inner dimension skips the loop and returns zero.
	assign go_mac  = in_take && is_compute && pos_ok && (inner_eff != '0);
	assign go_emit = in_take && is_compute && !(pos_ok && (inner_eff != '0));

	assign last     = (32'(l_q) == 32'(inner_eff) - 1);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		unique case (ctrl.cond)
			imm_pkg::COND_ALWAYS: step_next = ctrl.jmp;
			imm_pkg::COND_DISPATCH: begin
				priority if (go_mac) begin
					step_next = ctrl.jmp;
				end else if (go_emit) begin
					step_next = ctrl.alt;
				end else begin
					step_next = step_q;
				end
			end
			imm_pkg::COND_LAST:     step_next = last ? ctrl.jmp : ctrl.alt;
			imm_pkg::COND_OUT_FREE: step_next = out_free ? ctrl.jmp : ctrl.alt;
			default:                step_next = imm_pkg::STEP_IDLE;
		endcase
	end

	// Store ports: writes straight from the input word, reads from the loop.
	assign a_we = in_take && (func == imm_pkg::FUNC_WRITE_A) &&
		(32'(row_index) < 32'(rows_eff)) && (32'(col_index) < 32'(inner_eff));
	assign b_we = in_take && (func == imm_pkg::FUNC_WRITE_B) &&
		(32'(row_index) < 32'(inner_eff)) && (32'(col_index) < 32'(cols_eff));
	assign a_waddr = imm_pkg::LEFT_AW'(32'(row_index) * imm_pkg::MAX_INNER + 32'(col_index));
	assign b_waddr = imm_pkg::RIGHT_AW'(32'(row_index) * imm_pkg::MAX_COLS + 32'(col_index));
	assign a_raddr = imm_pkg::LEFT_AW'(32'(req_row_q) * imm_pkg::MAX_INNER + 32'(l_q));
	assign b_raddr = imm_pkg::RIGHT_AW'(32'(l_q) * imm_pkg::MAX_COLS + 32'(req_col_q));

	imm_ram #(
		.WIDTH (imm_pkg::DATA_W),
		.DEPTH (imm_pkg::LEFT_DEPTH)
	) u_left_store (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (element_value),
		.re    (ctrl.issue),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	imm_ram #(
		.WIDTH (imm_pkg::DATA_W),
		.DEPTH (imm_pkg::RIGHT_DEPTH)
	) u_right_store (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (element_value),
		.re    (ctrl.issue),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q        <= imm_pkg::STEP_IDLE;
			row_count_q   <= imm_pkg::COUNT_RESET;
			inner_count_q <= imm_pkg::COUNT_RESET;
			col_count_q   <= imm_pkg::COUNT_RESET;
			rd_vld_s1     <= 1'b0;
			prod_vld_s2   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			step_q      <= step_next;
			rd_vld_s1   <= ctrl.issue;
			prod_vld_s2 <= rd_vld_s1;
			if (cfg_valid) begin
				unique case (cfg_index)
					imm_pkg::CFG_ROW_COUNT:   row_count_q   <= cfg_data;
					imm_pkg::CFG_INNER_COUNT: inner_count_q <= cfg_data;
					imm_pkg::CFG_COL_COUNT:   col_count_q   <= cfg_data;
					default: ;
				endcase
			end
			if (ctrl.emit && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && is_compute) begin
			req_row_q <= row_index;
			req_col_q <= col_index;
			err_q     <= !pos_ok;
			l_q       <= '0;
		end else if (ctrl.issue) begin
			l_q <= l_q + 1'b1;
		end
		if (rd_vld_s1) begin
			prod_s2 <= a_rdata * b_rdata;
		end
		if (in_take && is_compute) begin
			acc_q <= '0;
		end else if (prod_vld_s2) begin
			acc_q <= acc_q + prod_s2;
		end
		if (ctrl.emit && out_free) begin
			product_value_q <= acc_q;
			status_q        <= err_q;
		end
	end

	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign product_value = product_value_q;
	assign status        = status_q;

endmodule

// ----- hdl/imm_checker.sv -----
module imm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [1:0]                        func,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [imm_pkg::DATA_W-1:0] product_value,
	input logic                              status
);

	// A held result word keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(product_value) && $stable(status))
	else $error("result word changed while stalled");

	// An error result always carries a zero sum.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> product_value == '0)
	else $error("error result with nonzero sum");

	// A C request blocks further input while it is worked on.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == imm_pkg::FUNC_COMPUTE |=> in_stall)
	else $error("input taken right after a C request");

	// A new result only appears out of the busy phase of a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
	else $error("result appeared while the block was idle");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.func          (func),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.product_value (product_value),
	.status        (status)
);

// ----- verif/imm_result_checker.sv -----
module imm_result_checker
	import imm_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [1:0]                func,
	input  logic [3:0]                row_index,
	input  logic [3:0]                col_index,
	input  logic signed [DATA_W-1:0]  element_value,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic signed [DATA_W-1:0]  product_value,
	input  logic                      status,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_IW-1:0]         cfg_index,
	input  logic [COUNT_W-1:0]        cfg_data,
	output int                        fail_count,
	output int                        pending_results,
	output int                        results_checked
);

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_OUTSIDE = 1'b1;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     status;
	} c_word_t;

	logic [DATA_W-1:0]  a_copy [LEFT_DEPTH];
	logic [DATA_W-1:0]  b_copy [RIGHT_DEPTH];
	logic [COUNT_W-1:0] rows_reg;
	logic [COUNT_W-1:0] inner_reg;
	logic [COUNT_W-1:0] cols_reg;
	c_word_t            c_words_due [$];
	c_word_t            due;
	int                 fails = 0;
	int                 checked = 0;

	// A size register above the store dimension acts as the full dimension.
	function automatic int used_count(logic [COUNT_W-1:0] reg_value, int most);
		return (reg_value > most) ? most : int'(reg_value);
	endfunction

	function automatic c_word_t predict_c_element(logic [3:0] r, logic [3:0] c);
		c_word_t           w;
		logic [DATA_W-1:0] acc;
		int                inner;
		w.value  = '0;
		w.status = STATUS_OUTSIDE;
		if (r >= used_count(rows_reg, MAX_ROWS) || c >= used_count(cols_reg, MAX_COLS))
			return w;
		acc   = '0;
		inner = used_count(inner_reg, MAX_INNER);
		for (int l = 0; l < inner; l++)
			acc = acc + a_copy[r * MAX_INNER + l] * b_copy[l * MAX_COLS + c];
		w.value  = acc;
		w.status = STATUS_OK;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg  = COUNT_RESET;
			inner_reg = COUNT_RESET;
			cols_reg  = COUNT_RESET;
			c_words_due.delete();
		end else begin
			// Results are taken before new words, so a stray result can never
			// be matched against a request accepted on the same edge.
			if (out_valid && !out_stall) begin
				checked++;
				if (c_words_due.size() == 0) begin
					$error("result word with no C request waiting: product_value %0d status %0d",
						product_value, status);
					fails++;
				end else begin
					due = c_words_due.pop_front();
					if (product_value !== due.value) begin
						$error("product_value: expected %0d, actual %0d", due.value, product_value);
						fails++;
					end
					if (status !== due.status) begin
						$error("status: expected %0d, actual %0d", due.status, status);
						fails++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				case (func)
					FUNC_WRITE_A: begin
						if (row_index < used_count(rows_reg, MAX_ROWS) &&
								col_index < used_count(inner_reg, MAX_INNER))
							a_copy[row_index * MAX_INNER + col_index] = element_value;
					end
					FUNC_WRITE_B: begin
						if (row_index < used_count(inner_reg, MAX_INNER) &&
								col_index < used_count(cols_reg, MAX_COLS))
							b_copy[row_index * MAX_COLS + col_index] = element_value;
					end
					FUNC_COMPUTE: begin
						c_words_due.push_back(predict_c_element(row_index, col_index));
					end
					default: begin
					end
				endcase
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ROW_COUNT:   rows_reg  = cfg_data;
					CFG_INNER_COUNT: inner_reg = cfg_data;
					CFG_COL_COUNT:   cols_reg  = cfg_data;
					default: begin
					end
				endcase
			end
		end
		fail_count      <= fails;
		pending_results <= c_words_due.size();
		results_checked <= checked;
	end

endmodule

// ----- verif/tb_integer_matrix_multiply.sv -----
module tb_integer_matrix_multiply;
	import imm_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int SETTLE_CYCLES  = MAX_INNER + 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int HOLD_AT_RESULT = 40;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [1:0]               func = '0;
	logic [3:0]               row_index = '0;
	logic [3:0]               col_index = '0;
	logic signed [DATA_W-1:0] element_value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] product_value;
	logic                     status;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IW-1:0]        cfg_index = '0;
	logic [COUNT_W-1:0]       cfg_data = '0;

	int fail_count;
	int pending_results;
	int results_checked;

	// Which store positions hold a value; a request inside the sizes may only
	// read positions marked here.
	bit a_done [LEFT_DEPTH];
	bit b_done [RIGHT_DEPTH];
	int rows_use, inner_use, cols_use;
	int setting_count = 0;
	int element_writes = 0;
	int c_requests = 0;
	int ignored_words = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int cycles;

	integer_matrix_multiply i_dut (.*);

	imm_result_checker i_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	// Result side: a random stall before each word, with steady stretches and
	// one long hold-off that lets the block back up into its input.
	initial begin : result_sink
		int wait_n;
		int taken;
		taken = 0;
		wait (arst_n);
		forever begin
			if (taken == HOLD_AT_RESULT)
				wait_n = HOLD_CYCLES;
			else if (rx_steady)
				wait_n = 0;
			else
				wait_n = $urandom_range(0, 6);
			if ($urandom_range(0, 23) == 0)
				rx_steady = !rx_steady;
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	function automatic int in_use(int reg_value, int most);
		return (reg_value > most) ? most : reg_value;
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 14)
			return $urandom();
		if (sel < 17)
			return DATA_W'($urandom_range(0, 16)) - DATA_W'(8);
		case (sel)
			17:      return 32'h8000_0000;
			18:      return 32'h7fff_ffff;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	function automatic bit c_inputs_written(int r, int c);
		for (int l = 0; l < inner_use; l++)
			if (!a_done[r * MAX_INNER + l] || !b_done[l * MAX_COLS + c])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic offer(input logic [1:0] f, input int r, input int c,
			input logic [DATA_W-1:0] v);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 6);
		if ($urandom_range(0, 39) == 0)
			tx_steady = !tx_steady;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		func          <= f;
		row_index     <= r[3:0];
		col_index     <= c[3:0];
		element_value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (f == FUNC_WRITE_A && r < rows_use && c < inner_use) begin
			a_done[r * MAX_INNER + c] = 1'b1;
			element_writes++;
		end else if (f == FUNC_WRITE_B && r < inner_use && c < cols_use) begin
			b_done[r * MAX_COLS + c] = 1'b1;
			element_writes++;
		end else if (f == FUNC_COMPUTE) begin
			c_requests++;
		end else begin
			ignored_words++;
		end
	endtask

	// Waits until every C request has been answered and the block has had time
	// to finish any write still in flight.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_sizes(input int r, input int i, input int c);
		logic [CFG_IW-1:0] idx [3];
		int                vals [3];
		idx[0]  = CFG_ROW_COUNT;
		idx[1]  = CFG_INNER_COUNT;
		idx[2]  = CFG_COL_COUNT;
		vals[0] = r;
		vals[1] = i;
		vals[2] = c;
		for (int k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data  <= COUNT_W'(vals[k]);
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		rows_use  = in_use(r, MAX_ROWS);
		inner_use = in_use(i, MAX_INNER);
		cols_use  = in_use(c, MAX_COLS);
		setting_count++;
	endtask

	task automatic random_item();
		logic [1:0] f;
		int         r, c, l, kind;
		kind = $urandom_range(0, 99);
		r    = $urandom_range(0, 15);
		c    = $urandom_range(0, 15);
		if (kind < 28 && rows_use > 0 && inner_use > 0) begin
			f = FUNC_WRITE_A;
			r = $urandom_range(0, rows_use - 1);
			c = $urandom_range(0, inner_use - 1);
		end else if (kind >= 28 && kind < 56 && inner_use > 0 && cols_use > 0) begin
			f = FUNC_WRITE_B;
			r = $urandom_range(0, inner_use - 1);
			c = $urandom_range(0, cols_use - 1);
		end else if (kind >= 56 && kind < 80 && rows_use > 0 && cols_use > 0) begin
			f = FUNC_COMPUTE;
			r = $urandom_range(0, rows_use - 1);
			c = $urandom_range(0, cols_use - 1);
		end else begin
			f = 2'($urandom_range(0, 3));
		end
		// A request inside the sizes must not read an element that was never
		// written, so it turns into a write of the first missing one.
		if (f == FUNC_COMPUTE && r < rows_use && c < cols_use && !c_inputs_written(r, c)) begin
			l = 0;
			while (l < inner_use && a_done[r * MAX_INNER + l]) l++;
			if (l < inner_use) begin
				f = FUNC_WRITE_A;
				c = l;
			end else begin
				l = 0;
				while (l < inner_use && b_done[l * MAX_COLS + c]) l++;
				f = FUNC_WRITE_B;
				r = l;
			end
		end
		offer(f, r, c, pick_value());
	endtask

	task automatic run_phase(input int r, input int i, input int c, input int quota);
		int target;
		settle();
		set_sizes(r, i, c);
		target = element_writes + c_requests + quota;
		while (element_writes + c_requests < target)
			random_item();
	endtask

	task automatic directed_checks();
		settle();
		set_sizes(2, 2, 2);
		offer(FUNC_WRITE_A, 0, 0, 32'h7fff_ffff);
		offer(FUNC_WRITE_A, 0, 1, 32'h8000_0000);
		offer(FUNC_WRITE_A, 1, 0, 32'hffff_ffff);
		offer(FUNC_WRITE_A, 1, 1, 32'h0000_0000);
		offer(FUNC_WRITE_B, 0, 0, 32'h7fff_ffff);
		offer(FUNC_WRITE_B, 0, 1, 32'hffff_ffff);
		offer(FUNC_WRITE_B, 1, 0, 32'h8000_0000);
		offer(FUNC_WRITE_B, 1, 1, 32'd12345);
		offer(FUNC_COMPUTE, 0, 0, '0);
		offer(FUNC_COMPUTE, 0, 1, '0);
		offer(FUNC_COMPUTE, 1, 0, '0);
		offer(FUNC_COMPUTE, 1, 1, '0);
		// Requests past the row or column size come back with an error status.
		offer(FUNC_COMPUTE, 2, 0, '0);
		offer(FUNC_COMPUTE, 0, 15, '0);
		offer(FUNC_COMPUTE, 15, 15, '0);
		// Writes past the sizes and the unused code must leave the stores alone.
		offer(FUNC_WRITE_A, 15, 15, 32'h5a5a_5a5a);
		offer(FUNC_WRITE_B, 15, 15, 32'ha5a5_a5a5);
		offer(FUNC_WRITE_A, 0, 2, 32'h1234_5678);
		offer(FUNC_WRITE_B, 2, 1, 32'h8765_4321);
		offer(FUNC_UNUSED, 15, 15, 32'hffff_ffff);
		offer(FUNC_COMPUTE, 0, 0, '0);
		offer(FUNC_COMPUTE, 1, 1, '0);
	endtask

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_checks();
		run_phase(16, 16, 16, 220);
		run_phase(1, 1, 1, 40);
		run_phase(5, 16, 3, 110);
		run_phase(16, 1, 16, 110);
		run_phase(0, 4, 4, 30);
		run_phase(4, 0, 4, 30);
		run_phase(31, 31, 31, 150);
		run_phase(3, 7, 0, 30);
		repeat (3)
			run_phase($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16), 60);
		settle();
		$display("Covered %0d size settings with %0d element writes,",
			setting_count, element_writes);
		$display("%0d C requests and %0d ignored words.", c_requests, ignored_words);
		$display("%0d result words were compared with the predicted C elements.", results_checked);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
